@@ hw/rtl/byte_vm_instruction_execute_macros.svh @@
// Assertion macros used by the checker file.
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_MACROS_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define BVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also holds while reset is applied.
`define BVM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bvm_pkg.sv @@
package bvm_pkg;

  localparam int DataW     = 8;
  localparam int RegAddrW  = 4;
  localparam int RegCnt    = 16;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 24;

  localparam logic [7:0] OP_LDC   = 8'h04;
  localparam logic [7:0] OP_SHL   = 8'h05;
  localparam logic [7:0] OP_JMP   = 8'h07;
  localparam logic [7:0] OP_JEOF  = 8'h0A;
  localparam logic [7:0] OP_HALT  = 8'h0B;
  localparam logic [7:0] OP_SUB   = 8'h0D;
  localparam logic [7:0] OP_XOR   = 8'h0E;
  localparam logic [7:0] OP_OR    = 8'h0F;
  localparam logic [7:0] OP_READ  = 8'h10;
  localparam logic [7:0] OP_WRITE = 8'h11;

  typedef logic [DataW-1:0]    byte_t;
  typedef logic [RegAddrW-1:0] reg_idx_t;

  typedef struct packed {
    logic     en;
    reg_idx_t addr;
    byte_t    data;
  } rf_wr_t;

  typedef struct packed {
    byte_t pc;
    logic  end_flag;
    logic  stopped;
  } arch_t;

  typedef struct packed {
    byte_t next_address;
    logic  out_valid;
    byte_t out_byte;
    logic  data_taken;
    logic  halted;
  } exec_res_t;

endpackage

@@ hw/rtl/bvm_regfile.sv @@
module bvm_regfile (
  input  logic             clk,
  input  logic             rst,
  input  bvm_pkg::rf_wr_t  wr,
  input  logic             rd_en,
  input  bvm_pkg::reg_idx_t rd_addr_x,
  input  bvm_pkg::reg_idx_t rd_addr_y,
  output bvm_pkg::byte_t   rd_data_x,
  output bvm_pkg::byte_t   rd_data_y
);
  import bvm_pkg::*;

  byte_t             mem [RegCnt];
  logic [RegCnt-1:0] written;
  byte_t             raw_x;
  byte_t             raw_y;
  logic              vld_x;
  logic              vld_y;
  logic              hit_x;
  logic              hit_y;
  byte_t             byp_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      raw_x <= mem[rd_addr_x];
      raw_y <= mem[rd_addr_y];
    end
  end

  // Entries not yet written read as zero, matching the reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // A write at the same edge as a read is forwarded to the reader.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_x <= 1'b0;
      vld_y <= 1'b0;
      hit_x <= 1'b0;
      hit_y <= 1'b0;
    end else if (rd_en) begin
      vld_x <= written[rd_addr_x];
      vld_y <= written[rd_addr_y];
      hit_x <= wr.en && (wr.addr == rd_addr_x);
      hit_y <= wr.en && (wr.addr == rd_addr_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rd_data_x = hit_x ? byp_data : (vld_x ? raw_x : '0);
  assign rd_data_y = hit_y ? byp_data : (vld_y ? raw_y : '0);

endmodule

@@ hw/rtl/bvm_exec.sv @@
module bvm_exec (
  input  bvm_pkg::byte_t    opcode,
  input  bvm_pkg::byte_t    operand,
  input  bvm_pkg::byte_t    data_byte,
  input  logic              data_at_end,
  input  bvm_pkg::byte_t    rx_val,
  input  bvm_pkg::byte_t    ry_val,
  input  bvm_pkg::arch_t    cur,
  output bvm_pkg::arch_t    nxt,
  output bvm_pkg::rf_wr_t   wr,
  output bvm_pkg::exec_res_t res
);
  import bvm_pkg::*;

  reg_idx_t rx;
  byte_t    seq_pc;
  byte_t    jmp_pc;

  assign rx     = operand[RegAddrW-1:0];
  assign seq_pc = cur.pc + byte_t'(2);
  assign jmp_pc = cur.pc + operand;

  always_comb begin
    nxt     = cur;
    nxt.pc  = seq_pc;
    wr.en   = 1'b0;
    wr.addr = rx;
    wr.data = '0;
    res     = '0;
    if (cur.stopped) begin
      nxt.pc = cur.pc;
    end else begin
      case (opcode)
        OP_LDC: begin
          wr.en   = 1'b1;
          wr.addr = '0;
          wr.data = operand;
        end
        OP_SHL: begin
          wr.en   = 1'b1;
          wr.data = {rx_val[DataW-2:0], 1'b0};
        end
        OP_JMP: begin
          nxt.pc = jmp_pc;
        end
        OP_JEOF: begin
          if (cur.end_flag) begin
            nxt.pc = jmp_pc;
          end
        end
        OP_HALT: begin
          nxt.stopped = 1'b1;
        end
        OP_SUB: begin
          wr.en   = 1'b1;
          wr.data = rx_val - ry_val;
        end
        OP_XOR: begin
          wr.en   = 1'b1;
          wr.data = rx_val ^ ry_val;
        end
        OP_OR: begin
          wr.en   = 1'b1;
          wr.data = rx_val | ry_val;
        end
        OP_READ: begin
          if (data_at_end) begin
            nxt.end_flag = 1'b1;
          end else begin
            wr.en          = 1'b1;
            wr.data        = data_byte;
            res.data_taken = 1'b1;
          end
        end
        OP_WRITE: begin
          res.out_valid = 1'b1;
          res.out_byte  = rx_val;
        end
        default: begin
        end
      endcase
    end
    res.next_address = nxt.pc;
    res.halted       = nxt.stopped;
  end

endmodule

@@ hw/rtl/byte_vm_instruction_execute.sv @@
// Executes one two-byte instruction per transaction for a small machine with
// sixteen 8-bit registers, an 8-bit program address, an end-of-data flag and
// a halt flag.
// The input channel s_* carries the fetched instruction and the data byte
// offered to a read; the output channel m_* returns one result transaction
// per input transaction: the next fetch address and the write, read and halt
// indications.
// The register file is a synchronous memory with two read ports. A transaction
// reads its registers when it is accepted, then waits in the execute stage; when
// it leaves that stage it writes back and its result is registered on m_*. A
// register written by one instruction is forwarded to the next one, so an
// instruction is accepted every cycle while the receiver does not stall.
// Reset clears the address, both flags and the output channel; the registers
// read as zero until first written, so no clearing pass is needed.
// When the receiver stalls, the result holds on m_*, one more instruction
// waits in the execute stage, and s_tready falls until m_tready returns.
module byte_vm_instruction_execute (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // opcode, operand, data_byte, data_at_end, zero fill
  input  logic [bvm_pkg::InTdataW-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // next_address, out_valid, out_byte, data_taken, halted, zero fill
  output logic [bvm_pkg::OutTdataW-1:0]    m_tdata
);
  import bvm_pkg::*;

  logic      s1_valid;
  byte_t     s1_opcode;
  byte_t     s1_operand;
  byte_t     s1_data_byte;
  logic      s1_data_at_end;
  arch_t     arch;
  arch_t     arch_next;
  rf_wr_t    ex_wr;
  rf_wr_t    rf_wr;
  exec_res_t ex_res;
  byte_t     rx_val;
  byte_t     ry_val;
  logic      out_free;
  logic      s1_fire;
  logic      accept;

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  assign rf_wr.en   = s1_fire && ex_wr.en;
  assign rf_wr.addr = ex_wr.addr;
  assign rf_wr.data = ex_wr.data;

  bvm_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (rf_wr),
    .rd_en     (accept),
    .rd_addr_x (s_tdata[11:8]),
    .rd_addr_y (s_tdata[15:12]),
    .rd_data_x (rx_val),
    .rd_data_y (ry_val)
  );

  bvm_exec u_exec (
    .opcode      (s1_opcode),
    .operand     (s1_operand),
    .data_byte   (s1_data_byte),
    .data_at_end (s1_data_at_end),
    .rx_val      (rx_val),
    .ry_val      (ry_val),
    .cur         (arch),
    .nxt         (arch_next),
    .wr          (ex_wr),
    .res         (ex_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      arch     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
        arch     <= arch_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode      <= s_tdata[7:0];
      s1_operand     <= s_tdata[15:8];
      s1_data_byte   <= s_tdata[23:16];
      s1_data_at_end <= s_tdata[24];
    end
    if (s1_fire) begin
      m_tdata <= {5'b0, ex_res.halted, ex_res.data_taken, ex_res.out_byte,
                  ex_res.out_valid, ex_res.next_address};
    end
  end

endmodule

@@ hw/rtl/bvm_checker.sv @@
`include "byte_vm_instruction_execute_macros.svh"

module bvm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [bvm_pkg::InTdataW-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bvm_pkg::OutTdataW-1:0] m_tdata
);
  import bvm_pkg::*;

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[18]) begin
      seen_halt <= 1'b1;
    end
  end

  `BVM_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")
  `BVM_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `BVM_ASSERT(a_halt_sticky, m_tvalid && seen_halt |-> m_tdata[18] && !m_tdata[8] && !m_tdata[17], "activity after halt")
  `BVM_ASSERT(a_quiet_fields, m_tvalid && !m_tdata[8] |-> m_tdata[16:9] == 8'h00 && !(m_tdata[17] && m_tdata[8]), "output byte without write")

endmodule

bind byte_vm_instruction_execute bvm_checker u_bvm_checker (.*);

@@ verif/testbench.sv @@
module testbench;
  import bvm_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // opcode, operand, data_byte, data_at_end, zero fill
  logic [InTdataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // next_address, out_valid, out_byte, data_taken, halted, zero fill
  logic [OutTdataW-1:0] m_tdata;

  byte_vm_instruction_execute i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  byte_t       vm_regs [RegCnt];
  byte_t       vm_pc = '0;
  logic        vm_eof = 1'b0;
  logic        vm_halted = 1'b0;
  exec_res_t   pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          use_gaps = 1'b1;
  bit          hold_off_request = 1'b0;

  initial begin
    foreach (vm_regs[i]) vm_regs[i] = '0;
  end

  function automatic exec_res_t execute_instruction(input logic [7:0] op,
                                                    input logic [7:0] arg,
                                                    input logic [7:0] dbyte,
                                                    input logic at_end);
    exec_res_t r;
    reg_idx_t  rx;
    reg_idx_t  ry;
    byte_t     next;
    rx = arg[3:0];
    ry = arg[7:4];
    next = vm_pc + 8'd2;
    r = '0;
    if (vm_halted) begin
      r.next_address = vm_pc;
      r.halted = 1'b1;
      return r;
    end
    case (op)
      OP_LDC:   vm_regs[0] = arg;
      OP_SHL:   vm_regs[rx] = {vm_regs[rx][6:0], 1'b0};
      OP_JMP:   next = vm_pc + arg;
      OP_JEOF:  if (vm_eof) next = vm_pc + arg;
      OP_HALT:  vm_halted = 1'b1;
      OP_SUB:   vm_regs[rx] = vm_regs[rx] - vm_regs[ry];
      OP_XOR:   vm_regs[rx] = vm_regs[rx] ^ vm_regs[ry];
      OP_OR:    vm_regs[rx] = vm_regs[rx] | vm_regs[ry];
      OP_READ: begin
        if (at_end) begin
          vm_eof = 1'b1;
        end else begin
          vm_regs[rx] = dbyte;
          r.data_taken = 1'b1;
        end
      end
      OP_WRITE: begin
        r.out_valid = 1'b1;
        r.out_byte = vm_regs[rx];
      end
      default: ;
    endcase
    vm_pc = next;
    r.next_address = next;
    r.halted = vm_halted;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    exec_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing expected", 32'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.next_address)
          report_mismatch("next_address", 32'(m_tdata[7:0]), 32'(want.next_address));
        if (m_tdata[8] !== want.out_valid)
          report_mismatch("out_valid", 32'(m_tdata[8]), 32'(want.out_valid));
        if (m_tdata[16:9] !== want.out_byte)
          report_mismatch("out_byte", 32'(m_tdata[16:9]), 32'(want.out_byte));
        if (m_tdata[17] !== want.data_taken)
          report_mismatch("data_taken", 32'(m_tdata[17]), 32'(want.data_taken));
        if (m_tdata[18] !== want.halted)
          report_mismatch("halted", 32'(m_tdata[18]), 32'(want.halted));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver changes its stall rate at random times and holds off
  // for a long stretch whenever a test asks for it.
  initial begin : receiver
    int unsigned mode_left;
    int unsigned stall_pct;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      @(posedge clk);
      if (hold_off_request) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off_request = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_instruction(input logic [7:0] op, input logic [7:0] arg,
                                  input logic [7:0] dbyte, input logic at_end);
    int unsigned gap;
    if (use_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, at_end, dbyte, arg, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(execute_instruction(op, arg, dbyte, at_end));
  endtask

  task automatic idle_input();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_instruction(input bit allow_end, input bit allow_halt);
    logic [7:0] op;
    logic       at_end;
    case ($urandom_range(0, 11))
      0:  op = OP_LDC;
      1:  op = OP_SHL;
      2:  op = OP_JMP;
      3:  op = OP_JEOF;
      4:  op = OP_SUB;
      5:  op = OP_XOR;
      6:  op = OP_OR;
      7:  op = OP_READ;
      8:  op = OP_READ;
      9:  op = OP_WRITE;
      10: op = OP_WRITE;
      default: op = 8'($urandom_range(0, 255));
    endcase
    if (op == OP_HALT && !allow_halt) op = OP_LDC;
    at_end = 1'($urandom_range(0, 1));
    if (op == OP_READ && !allow_end) at_end = 1'b0;
    send_instruction(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), at_end);
  endtask

  task automatic test_directed();
    send_instruction(OP_LDC,   8'hFF, 8'h00, 1'b0);
    send_instruction(OP_WRITE, 8'h00, 8'hFF, 1'b1);
    send_instruction(OP_LDC,   8'h00, 8'h00, 1'b0);
    send_instruction(OP_READ,  8'h01, 8'hA5, 1'b0);
    send_instruction(OP_READ,  8'h0F, 8'hFF, 1'b0);
    send_instruction(OP_READ,  8'h02, 8'h00, 1'b0);
    send_instruction(OP_SUB,   8'h12, 8'h00, 1'b0);
    send_instruction(OP_XOR,   8'h1F, 8'h00, 1'b0);
    send_instruction(OP_OR,    8'hF1, 8'h00, 1'b0);
    send_instruction(OP_SHL,   8'h0F, 8'h00, 1'b0);
    send_instruction(OP_SUB,   8'hFF, 8'h00, 1'b0);
    send_instruction(OP_WRITE, 8'h02, 8'h00, 1'b0);
    send_instruction(OP_WRITE, 8'h0F, 8'h00, 1'b0);
    send_instruction(OP_WRITE, 8'hF1, 8'h00, 1'b0);
    send_instruction(OP_JMP,   8'h7F, 8'h00, 1'b0);
    send_instruction(OP_JMP,   8'h80, 8'h00, 1'b0);
    send_instruction(OP_JMP,   8'hFF, 8'h00, 1'b0);
    send_instruction(OP_JMP,   8'h00, 8'h00, 1'b0);
    send_instruction(OP_JEOF,  8'h10, 8'h00, 1'b0);
    send_instruction(8'h00,    8'h00, 8'h00, 1'b0);
    send_instruction(8'hFF,    8'hFF, 8'hFF, 1'b1);
    send_instruction(8'h06,    8'h33, 8'h00, 1'b0);
    send_instruction(8'h0C,    8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_random(input int unsigned count, input bit allow_end);
    repeat (count) send_random_instruction(allow_end, 1'b0);
  endtask

  task automatic test_end_of_data();
    send_instruction(OP_READ,  8'h03, 8'h5A, 1'b1);
    send_instruction(OP_WRITE, 8'h03, 8'h00, 1'b0);
    send_instruction(OP_JEOF,  8'hF0, 8'h00, 1'b0);
    send_instruction(OP_READ,  8'h04, 8'h77, 1'b0);
    send_instruction(OP_JEOF,  8'h7F, 8'h00, 1'b0);
    send_instruction(OP_WRITE, 8'h04, 8'h00, 1'b0);
  endtask

  // The receiver holds off while items keep coming without gaps, so the
  // block fills up and stalls its input; afterwards the sender waits
  // until every result has come.
  task automatic test_backpressure();
    use_gaps = 1'b0;
    hold_off_request = 1'b1;
    repeat (40) send_random_instruction(1'b1, 1'b0);
    use_gaps = 1'b1;
    wait_for_results();
  endtask

  task automatic test_halt();
    send_instruction(OP_WRITE, 8'h00, 8'h00, 1'b0);
    send_instruction(OP_HALT,  8'hFF, 8'hFF, 1'b1);
    send_instruction(OP_WRITE, 8'h00, 8'h00, 1'b0);
    send_instruction(OP_HALT,  8'h00, 8'h00, 1'b0);
    repeat (40) send_random_instruction(1'b1, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800, 1'b0);
    test_end_of_data();
    test_backpressure();
    test_random(900, 1'b1);
    test_halt();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ byte_vm_instruction_execute.f @@
+incdir+hw/rtl
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_regfile.sv
hw/rtl/bvm_exec.sv
hw/rtl/byte_vm_instruction_execute.sv
hw/rtl/bvm_checker.sv
verif/testbench.sv
